// ----- sv/chte_pkg.sv -----
// shared types and constants of the chained hash table engine
package chte_pkg;

  localparam int unsigned MAX_BUCKETS  = 256;
  localparam int unsigned POOL_ENTRIES = 1024;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned BB_W     = 4;

  localparam logic [BB_W-1:0] BB_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDATA,
    S_WALK,
    S_FREE,
    S_DONE
  } state_e;

  // entry pool controls
  typedef struct packed {
    logic rd;
    logic kh_we;
    logic link_we;
  } pool_ctl_t;

  // bucket head table controls
  typedef struct packed {
    logic rd;
    logic we;
  } head_ctl_t;

endpackage

// ----- sv/chained_hash_table_engine.sv -----
// top level of the chained hash table engine: sequencer, free list and result register
// A hash table with separate chaining over a fixed pool of entries. Each item is an
// insert, delete or lookup of a 32-bit key; each item gives one result with a status,
// the matched handle and the entry count after the operation. The bucket is the key
// masked to bucket_bits low bits (0 acts as 1, values beyond the table are clamped).
// One item is worked on at a time by a sequencer around a single key comparator and
// single-port memories with registered reads. An insert, an op of three, or a delete
// or lookup in an empty bucket passes from S_IDLE through S_HDATA to S_DONE. A delete
// or lookup in a nonempty bucket goes on to S_WALK and walks the chain one entry per
// cycle until the match or the end of the chain; a delete that hits then passes S_FREE
// (the freed slot is linked onto the free list). Input is stalled while an item is in
// work; the output register lets the next item start while a result still waits. No
// clearing pass is needed after reset: the initial free list comes from a fill count.
module chained_hash_table_engine #(
  parameter int unsigned MAX_BUCKETS  = chte_pkg::MAX_BUCKETS,
  parameter int unsigned POOL_ENTRIES = chte_pkg::POOL_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [chte_pkg::BB_W-1:0]     cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [chte_pkg::OP_W-1:0]     op_i,
  input  logic [chte_pkg::KEY_W-1:0]    key_i,
  input  logic [chte_pkg::HANDLE_W-1:0] handle_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [chte_pkg::STATUS_W-1:0] status_o,
  output logic [chte_pkg::HANDLE_W-1:0] found_handle_o,
  output logic [chte_pkg::COUNT_W-1:0]  entry_count_o
);

  localparam int unsigned HW     = $clog2(MAX_BUCKETS);
  localparam int unsigned SW     = $clog2(POOL_ENTRIES);
  localparam int unsigned CW     = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned BB_MAX = $clog2(MAX_BUCKETS + 1) - 1;  // floor of log2

  chte_pkg::state_e state_q, state_d;

  logic [chte_pkg::BB_W-1:0]     bb_q;
  chte_pkg::op_e                 op_q, op_d;
  logic [chte_pkg::KEY_W-1:0]    key_q, key_d;
  logic [chte_pkg::HANDLE_W-1:0] handle_q, handle_d;
  logic [HW-1:0]                 bucket_q, bucket_d;
  logic [SW-1:0]                 cur_q, cur_d, prev_q, prev_d;
  logic                          have_prev_q, have_prev_d;
  logic                          free_valid_q, free_valid_d;
  logic [SW-1:0]                 free_head_q, free_head_d;
  logic [CW-1:0]                 count_q, count_d;
  chte_pkg::status_e             res_status_q, res_status_d;
  logic [chte_pkg::HANDLE_W-1:0] res_handle_q, res_handle_d;

  logic                          out_valid_q, out_valid_d;
  logic [chte_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [chte_pkg::HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [chte_pkg::COUNT_W-1:0]  out_count_q, out_count_d;

  // effective bucket mask
  logic [chte_pkg::BB_W-1:0]  eff_bits;
  logic [chte_pkg::KEY_W-1:0] key_mask;

  // memory ports
  chte_pkg::pool_ctl_t           pool_ctl;
  logic [SW-1:0]                 pool_rd_addr, pool_wr_addr;
  logic                          pool_wr_link_valid;
  logic [SW-1:0]                 pool_wr_link_slot;
  logic [chte_pkg::KEY_W-1:0]    pool_rd_key;
  logic [chte_pkg::HANDLE_W-1:0] pool_rd_handle;
  logic                          pool_rd_link_valid;
  logic [SW-1:0]                 pool_rd_link_slot;

  chte_pkg::head_ctl_t head_ctl;
  logic                head_wr_valid;
  logic [SW-1:0]       head_wr_slot;
  logic                head_rd_valid;
  logic [SW-1:0]       head_rd_slot;

  logic key_hit;

  // config is always taken; the user writes only while idle
  assign cfg_ready_o = 1'b1;

  always_comb begin
    eff_bits = bb_q;
    if (bb_q == '0) begin
      eff_bits = chte_pkg::BB_W'(1);
    end else if (bb_q > chte_pkg::BB_W'(BB_MAX)) begin
      eff_bits = chte_pkg::BB_W'(BB_MAX);
    end
  end

  assign key_mask = ~({chte_pkg::KEY_W{1'b1}} << eff_bits);
  assign key_hit  = (pool_rd_key == key_q);

  assign in_stall_o = (state_q != chte_pkg::S_IDLE);

  chte_pool #(
    .POOL_ENTRIES(POOL_ENTRIES)
  ) u_pool (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (pool_ctl),
    .rd_addr_i      (pool_rd_addr),
    .wr_addr_i      (pool_wr_addr),
    .wr_key_i       (key_q),
    .wr_handle_i    (handle_q),
    .wr_link_valid_i(pool_wr_link_valid),
    .wr_link_slot_i (pool_wr_link_slot),
    .rd_key_o       (pool_rd_key),
    .rd_handle_o    (pool_rd_handle),
    .rd_link_valid_o(pool_rd_link_valid),
    .rd_link_slot_o (pool_rd_link_slot)
  );

  chte_heads #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_ENTRIES(POOL_ENTRIES)
  ) u_heads (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (head_ctl),
    .rd_addr_i (bucket_d),
    .wr_addr_i (bucket_q),
    .wr_valid_i(head_wr_valid),
    .wr_slot_i (head_wr_slot),
    .rd_valid_o(head_rd_valid),
    .rd_slot_o (head_rd_slot)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    handle_d     = handle_q;
    bucket_d     = bucket_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    free_valid_d = free_valid_q;
    free_head_d  = free_head_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_count_d  = out_count_q;

    pool_ctl           = '0;
    pool_rd_addr       = free_head_q;
    pool_wr_addr       = free_head_q;
    pool_wr_link_valid = head_rd_valid;
    pool_wr_link_slot  = head_rd_slot;
    head_ctl           = '0;
    head_wr_valid      = 1'b1;
    head_wr_slot       = free_head_q;

    unique case (state_q)
      chte_pkg::S_IDLE: begin
        if (in_valid_i) begin
          // read bucket head and the free slot's link at once
          op_d         = chte_pkg::op_e'(op_i);
          key_d        = key_i;
          handle_d     = handle_i;
          bucket_d     = HW'(key_i & key_mask);
          head_ctl.rd  = 1'b1;
          pool_ctl.rd  = 1'b1;
          state_d      = chte_pkg::S_HDATA;
        end
      end

      chte_pkg::S_HDATA: begin
        res_handle_d = '0;
        state_d      = chte_pkg::S_DONE;
        unique case (op_q)
          chte_pkg::OP_INSERT: begin
            if (!free_valid_q) begin
              res_status_d = chte_pkg::ST_FULL;
            end else begin
              // push the free slot on the head of the chain
              pool_ctl.kh_we   = 1'b1;
              pool_ctl.link_we = 1'b1;
              head_ctl.we      = 1'b1;
              free_valid_d     = pool_rd_link_valid;
              free_head_d      = pool_rd_link_slot;
              count_d          = count_q + 1'b1;
              res_status_d     = chte_pkg::ST_OK;
            end
          end
          chte_pkg::OP_DELETE, chte_pkg::OP_LOOKUP: begin
            if (!head_rd_valid) begin
              res_status_d = chte_pkg::ST_MISS;
            end else begin
              pool_ctl.rd  = 1'b1;
              pool_rd_addr = head_rd_slot;
              cur_d        = head_rd_slot;
              have_prev_d  = 1'b0;
              state_d      = chte_pkg::S_WALK;
            end
          end
          default: begin
            res_status_d = chte_pkg::ST_MISS;
          end
        endcase
      end

      chte_pkg::S_WALK: begin
        if (key_hit) begin
          res_status_d = chte_pkg::ST_OK;
          res_handle_d = pool_rd_handle;
          state_d      = chte_pkg::S_DONE;
          if (op_q == chte_pkg::OP_DELETE) begin
            // unlink from predecessor or from the bucket head
            pool_wr_link_valid = pool_rd_link_valid;
            pool_wr_link_slot  = pool_rd_link_slot;
            pool_wr_addr       = prev_q;
            head_wr_valid      = pool_rd_link_valid;
            head_wr_slot       = pool_rd_link_slot;
            if (have_prev_q) begin
              pool_ctl.link_we = 1'b1;
            end else begin
              head_ctl.we = 1'b1;
            end
            state_d = chte_pkg::S_FREE;
          end
        end else if (!pool_rd_link_valid) begin
          res_status_d = chte_pkg::ST_MISS;
          res_handle_d = '0;
          state_d      = chte_pkg::S_DONE;
        end else begin
          pool_ctl.rd  = 1'b1;
          pool_rd_addr = pool_rd_link_slot;
          prev_d       = cur_q;
          have_prev_d  = 1'b1;
          cur_d        = pool_rd_link_slot;
        end
      end

      chte_pkg::S_FREE: begin
        // return the slot to the head of the free list
        pool_ctl.link_we   = 1'b1;
        pool_wr_addr       = cur_q;
        pool_wr_link_valid = free_valid_q;
        pool_wr_link_slot  = free_head_q;
        free_valid_d       = 1'b1;
        free_head_d        = cur_q;
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
        state_d = chte_pkg::S_DONE;
      end

      chte_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          out_count_d  = chte_pkg::COUNT_W'(count_q);
          state_d      = chte_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = chte_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= chte_pkg::S_IDLE;
      bb_q         <= chte_pkg::BB_RESET;
      free_valid_q <= 1'b1;
      free_head_q  <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_valid_q <= free_valid_d;
      free_head_q  <= free_head_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        bb_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    handle_q     <= handle_d;
    bucket_q     <= bucket_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    have_prev_q  <= have_prev_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_handle_o = out_handle_q;
  assign entry_count_o  = out_count_q;

  // the pool never holds more entries than it has slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(POOL_ENTRIES))
    else $error("entry count beyond pool size");

  // free list runs dry only when every slot is in use
  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !free_valid_q |-> (count_q == CW'(POOL_ENTRIES)))
    else $error("free list empty with slots unused");

  // slot release follows only a delete hit in the chain walk
  a_free_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chte_pkg::S_FREE) |->
      ($past(state_q) == chte_pkg::S_WALK) && (op_q == chte_pkg::OP_DELETE))
    else $error("slot released outside a delete");

endmodule

// ----- sv/chte_pool.sv -----
// entry pool: key, handle and link memories with fill count for the initial free list
module chte_pool #(
  parameter int unsigned POOL_ENTRIES = chte_pkg::POOL_ENTRIES,
  localparam int unsigned SW = $clog2(POOL_ENTRIES),
  localparam int unsigned FW = $clog2(POOL_ENTRIES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chte_pkg::pool_ctl_t           ctl_i,
  input  logic [SW-1:0]                 rd_addr_i,
  input  logic [SW-1:0]                 wr_addr_i,
  input  logic [chte_pkg::KEY_W-1:0]    wr_key_i,
  input  logic [chte_pkg::HANDLE_W-1:0] wr_handle_i,
  input  logic                          wr_link_valid_i,
  input  logic [SW-1:0]                 wr_link_slot_i,
  output logic [chte_pkg::KEY_W-1:0]    rd_key_o,
  output logic [chte_pkg::HANDLE_W-1:0] rd_handle_o,
  output logic                          rd_link_valid_o,
  output logic [SW-1:0]                 rd_link_slot_o
);

  logic [chte_pkg::KEY_W-1:0]    keys_mem    [POOL_ENTRIES];
  logic [chte_pkg::HANDLE_W-1:0] handles_mem [POOL_ENTRIES];
  logic [SW:0]                   links_mem   [POOL_ENTRIES];

  logic [FW-1:0] fill_q, fill_d;
  logic [SW-1:0] addr_q;
  logic          fresh_q;
  logic [SW:0]   link_q;
  logic [SW-1:0] next_slot;

  // slots at or above the fill count still hold their reset link
  always_comb begin
    fill_d = fill_q;
    if (ctl_i.link_we && ({1'b0, wr_addr_i} == fill_q)) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (ctl_i.rd) begin
        fresh_q <= ({1'b0, rd_addr_i} >= fill_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.kh_we) begin
      keys_mem[wr_addr_i]    <= wr_key_i;
      handles_mem[wr_addr_i] <= wr_handle_i;
    end
    if (ctl_i.link_we) begin
      links_mem[wr_addr_i] <= {wr_link_valid_i, wr_link_slot_i};
    end
    if (ctl_i.rd) begin
      rd_key_o    <= keys_mem[rd_addr_i];
      rd_handle_o <= handles_mem[rd_addr_i];
      link_q      <= links_mem[rd_addr_i];
      addr_q      <= rd_addr_i;
    end
  end

  // reset chain: slot i links to i+1, last slot has no successor
  assign next_slot = (addr_q == SW'(POOL_ENTRIES - 1)) ? '0 : addr_q + 1'b1;

  assign rd_link_valid_o = fresh_q ? (addr_q != SW'(POOL_ENTRIES - 1)) : link_q[SW];
  assign rd_link_slot_o  = fresh_q ? next_slot : link_q[SW-1:0];

endmodule

// ----- sv/chte_heads.sv -----
// bucket head table: head slot memory with per-bucket valid bits
module chte_heads #(
  parameter int unsigned MAX_BUCKETS  = chte_pkg::MAX_BUCKETS,
  parameter int unsigned POOL_ENTRIES = chte_pkg::POOL_ENTRIES,
  localparam int unsigned HW = $clog2(MAX_BUCKETS),
  localparam int unsigned SW = $clog2(POOL_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chte_pkg::head_ctl_t ctl_i,
  input  logic [HW-1:0]       rd_addr_i,
  input  logic [HW-1:0]       wr_addr_i,
  input  logic                wr_valid_i,
  input  logic [SW-1:0]       wr_slot_i,
  output logic                rd_valid_o,
  output logic [SW-1:0]       rd_slot_o
);

  logic [SW-1:0]          slots_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        valid_q[wr_addr_i] <= wr_valid_i;
      end
      if (ctl_i.rd) begin
        rd_valid_o <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      slots_mem[wr_addr_i] <= wr_slot_i;
    end
    if (ctl_i.rd) begin
      rd_slot_o <= slots_mem[rd_addr_i];
    end
  end

endmodule
